>>> rtl/core/aer_pkg.sv
// aer_pkg: shared types, widths and reset values for the acoustic echo ranger.
// Used by aer_front, aer_back and acoustic_echo_ranger_top.
// No dependencies.
package aer_pkg;

  localparam int SampleBits    = 16;
  localparam int TimerBitsDef  = 24;
  localparam int QueueDepthDef = 4;

  localparam int AccBits      = 31;
  localparam int PeakBits     = 16;
  localparam int LevelBits    = 16;
  localparam int SensBits     = 8;
  localparam int WinBits      = 4;
  localparam int IntervalBits = 24;
  localparam int DpsBits      = 16;
  localparam int DistBits     = 40;
  localparam int MulBits      = AccBits + SensBits;

  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

  localparam logic [IntervalBits-1:0] PingIntervalRst = 24'd44100;
  localparam logic [SensBits-1:0]     SensitivityRst  = 8'd32;
  localparam logic [WinBits-1:0]      AvgWindowRst    = 4'd12;
  localparam logic [DpsBits-1:0]      DistPerSmpRst   = 16'd7778;

  localparam int AddrBits = 4;
  localparam int DataBits = 32;

  typedef enum logic [1:0] {
    RegPingInterval  = 2'd0,
    RegSensitivity   = 2'd1,
    RegAvgWindow     = 2'd2,
    RegDistPerSample = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         block_end;
  } in_item_t;

  typedef struct packed {
    logic                 echo_detected;
    logic [DistBits-1:0]  distance_um;
    logic                 ping_request;
    logic [PeakBits-1:0]  block_peak;
    logic [LevelBits-1:0] mean_level;
  } out_item_t;

endpackage

>>> rtl/core/aer_fifo.sv
// aer_fifo: short register-based queue between the front and back sections.
// Depends on nothing but its parameters.
module aer_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] DepthCnt = CntBits'(DEPTH);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("aer_fifo: push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("aer_fifo: pop from empty queue");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("aer_fifo: occupancy beyond depth");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("aer_fifo: occupancy did not track push");

endmodule

>>> rtl/core/aer_front.sv
// aer_front: per-sample state update (running sum, block peak, ping counter).
// Pushes one job per block end into the queue. Depends on aer_pkg.
module aer_front #(
  parameter int TIMER_BITS = aer_pkg::TimerBitsDef,
  parameter int JOB_BITS   = 1 + aer_pkg::PeakBits + aer_pkg::AccBits + TIMER_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  aer_pkg::in_item_t                 in_data_i,
  input  logic [aer_pkg::WinBits-1:0]       win_log2_i,
  input  logic [aer_pkg::IntervalBits-1:0]  ping_interval_i,
  input  logic                              full_i,
  output logic                              push_o,
  output logic [JOB_BITS-1:0]               job_o
);

  localparam int CmpBits = (TIMER_BITS > aer_pkg::IntervalBits) ?
                           TIMER_BITS : aer_pkg::IntervalBits;

  logic [aer_pkg::AccBits-1:0]    acc_q, acc_d;
  logic [aer_pkg::PeakBits-1:0]   peak_q, peak_d;
  logic [TIMER_BITS-1:0]          cnt_q, cnt_d;
  logic [TIMER_BITS-1:0]          elapsed_q, elapsed_d;
  logic                           open_q, open_d;

  logic                           accept;
  logic [aer_pkg::SampleBits-1:0] raw;
  logic [aer_pkg::PeakBits-1:0]   mag;
  logic [aer_pkg::PeakBits-1:0]   peak_base;
  logic [TIMER_BITS-1:0]          cnt_inc;
  logic                           ping;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && in_data_i.block_end;

  always_comb begin
    raw       = in_data_i.sample;
    mag       = raw[aer_pkg::SampleBits-1] ? (~raw + 1'b1) : raw;
    peak_base = open_q ? peak_q : '0;
    cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    ping      = CmpBits'(cnt_inc) >= CmpBits'(ping_interval_i);

    acc_d     = acc_q - (acc_q >> win_log2_i) + aer_pkg::AccBits'(mag);
    peak_d    = (mag > peak_base) ? mag : peak_base;
    // latch the counter before the opening sample is counted
    elapsed_d = open_q ? elapsed_q : cnt_q;
    if (in_data_i.block_end) begin
      open_d = 1'b0;
      cnt_d  = ping ? '0 : cnt_inc;
    end else begin
      open_d = 1'b1;
      cnt_d  = cnt_inc;
    end
  end

  assign job_o = {ping, peak_d, acc_d, elapsed_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      peak_q    <= '0;
      cnt_q     <= '0;
      elapsed_q <= '0;
      open_q    <= 1'b0;
    end else if (accept) begin
      acc_q     <= acc_d;
      peak_q    <= peak_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      open_q    <= open_d;
    end
  end

endmodule

>>> rtl/core/aer_back.sv
// aer_back: threshold test and distance product, two registered stages.
// Pops jobs from the queue and drives the result register. Depends on aer_pkg.
module aer_back #(
  parameter int TIMER_BITS = aer_pkg::TimerBitsDef,
  parameter int JOB_BITS   = 1 + aer_pkg::PeakBits + aer_pkg::AccBits + TIMER_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  logic [JOB_BITS-1:0]          job_i,
  output logic                         pop_o,
  input  logic [aer_pkg::WinBits-1:0]  win_log2_i,
  input  logic [aer_pkg::SensBits-1:0] sens_i,
  input  logic [aer_pkg::DpsBits-1:0]  dps_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output aer_pkg::out_item_t           out_data_o
);

  localparam int ProdBits = TIMER_BITS + aer_pkg::DpsBits;
  localparam int ExtBits  = (ProdBits > aer_pkg::DistBits) ? ProdBits : aer_pkg::DistBits + 1;

  logic                           j_ping;
  logic [aer_pkg::PeakBits-1:0]   j_peak;
  logic [aer_pkg::AccBits-1:0]    j_acc;
  logic [TIMER_BITS-1:0]          j_elapsed;
  logic [aer_pkg::AccBits-1:0]    mean;

  logic                           a_valid_q;
  logic [aer_pkg::MulBits-1:0]    a_mul_q, a_mul_d;
  logic [ProdBits-1:0]            a_prod_q, a_prod_d;
  logic [aer_pkg::PeakBits-1:0]   a_peak_q;
  logic [aer_pkg::LevelBits-1:0]  a_mean_q;
  logic                           a_ping_q;

  logic                           out_valid_q;
  aer_pkg::out_item_t             out_q, out_d;

  logic                           a_ready;
  logic                           b_ready;
  logic [ExtBits-1:0]             prod_x;
  logic [aer_pkg::MulBits-1:0]    peak_x16;
  logic                           echo;

  assign {j_ping, j_peak, j_acc, j_elapsed} = job_i;

  assign b_ready = !out_valid_q || out_ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign pop_o   = job_valid_i && a_ready;

  always_comb begin
    mean     = j_acc >> win_log2_i;
    a_mul_d  = aer_pkg::MulBits'(mean) * aer_pkg::MulBits'(sens_i);
    a_prod_d = ProdBits'(j_elapsed) * ProdBits'(dps_i);
  end

  always_comb begin
    prod_x   = ExtBits'(a_prod_q);
    peak_x16 = aer_pkg::MulBits'(a_peak_q) << 4;
    echo     = peak_x16 > a_mul_q;
    out_d.echo_detected = echo;
    if (!echo) begin
      out_d.distance_um = '0;
    end else if (prod_x > ExtBits'(aer_pkg::DistMax)) begin
      out_d.distance_um = aer_pkg::DistMax;
    end else begin
      out_d.distance_um = prod_x[aer_pkg::DistBits-1:0];
    end
    out_d.ping_request = a_ping_q;
    out_d.block_peak   = a_peak_q;
    out_d.mean_level   = a_mean_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= job_valid_i;
      end
      if (b_ready) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_mul_q  <= a_mul_d;
      a_prod_q <= a_prod_d;
      a_peak_q <= j_peak;
      a_mean_q <= mean[aer_pkg::LevelBits-1:0];
      a_ping_q <= j_ping;
    end
    if (b_ready && a_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stage_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_ready) |=> out_valid_q)
    else $error("aer_back: stage result lost on its way to the output");

  a_hold_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_ready) |=> (a_valid_q && $stable(a_mul_q) && $stable(a_prod_q)))
    else $error("aer_back: stalled stage changed");

endmodule

>>> rtl/core/acoustic_echo_ranger_top.sv
// acoustic_echo_ranger_top: echo detector with running-average threshold.
// Holds the configuration registers; instantiates aer_front, aer_fifo, aer_back.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   in_data_i  (aer_pkg::in_item_t)
//   out      source     out_valid_o / out_ready_i out_data_o (aer_pkg::out_item_t)
//   cfg      APB slave  psel, penable, pready     paddr, pwdata, prdata
//
// One sample accepted per cycle while the queue is not full; each block end yields one result.
// The front updates its state in the cycle of acceptance; the back is two stages
// (mean times sensitivity and elapsed times distance, then compare and saturate).
// Reset clears all running state and loads the default register values.
// The queue holds QUEUE_DEPTH pending results; in_ready_o drops only when it is full.
module acoustic_echo_ranger_top #(
  parameter int TIMER_BITS  = aer_pkg::TimerBitsDef,
  parameter int QUEUE_DEPTH = aer_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aer_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aer_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aer_pkg::AddrBits-1:0]  paddr,
  input  logic [aer_pkg::DataBits-1:0]  pwdata,
  output logic [aer_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);

  localparam int JobBits = 1 + aer_pkg::PeakBits + aer_pkg::AccBits + TIMER_BITS;

  logic [aer_pkg::IntervalBits-1:0] ping_interval_q;
  logic [aer_pkg::SensBits-1:0]     sens_q;
  logic [aer_pkg::WinBits-1:0]      win_q;
  logic [aer_pkg::DpsBits-1:0]      dps_q;

  logic                 wr_en;
  aer_pkg::reg_idx_e    reg_idx;

  logic                 push;
  logic                 full;
  logic [JobBits-1:0]   push_job;
  logic                 job_valid;
  logic                 pop;
  logic [JobBits-1:0]   pop_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = aer_pkg::reg_idx_e'(paddr[aer_pkg::AddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_interval_q <= aer_pkg::PingIntervalRst;
      sens_q          <= aer_pkg::SensitivityRst;
      win_q           <= aer_pkg::AvgWindowRst;
      dps_q           <= aer_pkg::DistPerSmpRst;
    end else if (wr_en) begin
      case (reg_idx)
        aer_pkg::RegPingInterval:  ping_interval_q <= pwdata[aer_pkg::IntervalBits-1:0];
        aer_pkg::RegSensitivity:   sens_q          <= pwdata[aer_pkg::SensBits-1:0];
        aer_pkg::RegAvgWindow:     win_q           <= pwdata[aer_pkg::WinBits-1:0];
        aer_pkg::RegDistPerSample: dps_q           <= pwdata[aer_pkg::DpsBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aer_pkg::RegPingInterval:  prdata = aer_pkg::DataBits'(ping_interval_q);
      aer_pkg::RegSensitivity:   prdata = aer_pkg::DataBits'(sens_q);
      aer_pkg::RegAvgWindow:     prdata = aer_pkg::DataBits'(win_q);
      aer_pkg::RegDistPerSample: prdata = aer_pkg::DataBits'(dps_q);
      default:                   prdata = '0;
    endcase
  end

  aer_front #(
    .TIMER_BITS (TIMER_BITS),
    .JOB_BITS   (JobBits)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .win_log2_i      (win_q),
    .ping_interval_i (ping_interval_q),
    .full_i          (full),
    .push_o          (push),
    .job_o           (push_job)
  );

  aer_fifo #(
    .WIDTH (JobBits),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .rdata_o (pop_job)
  );

  aer_back #(
    .TIMER_BITS (TIMER_BITS),
    .JOB_BITS   (JobBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .win_log2_i  (win_q),
    .sens_i      (sens_q),
    .dps_i       (dps_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
